>>> hdl/scs_pkg.sv
// ----------------------------------------------------------------------------
// scs_pkg
// Shared types and constants of the scan centroid steering block.
// ----------------------------------------------------------------------------
package scs_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SPEED_W  = 13;
  localparam int TURN_W   = 27;
  localparam int CFG_IDX_W = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_FLOOR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_CEILING = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP    = 2'd2;

  localparam logic [SAMPLE_W-1:0] RANGE_FLOOR_RST   = 16'd0;
  localparam logic [SAMPLE_W-1:0] RANGE_CEILING_RST = 16'hFFFF;
  localparam logic [SAMPLE_W-1:0] ANGLE_STEP_RST    = 16'd0;

  // pi in 2^-16 rad, truncated
  localparam logic [TURN_W-1:0]  PI_FIXED      = 27'd205887;
  localparam logic [SPEED_W-1:0] SLOW_LIMIT    = 13'd500;
  localparam logic [SPEED_W-1:0] DEFAULT_SPEED = 13'd1000;

  // x / 10 == (x * 52429) >> 19 for every 16-bit x
  localparam int RECIP_W = 32;
  localparam logic [RECIP_W-1:0] RECIP_TEN = 32'd52429;
  localparam int RECIP_SHIFT = 19;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_LOAD,
    ST_DIVIDE,
    ST_SCALE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accum;     // a sample request is taken this cycle
    logic div_load;  // latch totals into the divider
    logic div_step;  // one restoring division step
    logic scale;     // divide the mean range by ten
    logic finish;    // publish the result and clear the scan state
  } cmd_t;

endpackage

>>> hdl/scan_centroid_steering.sv
// Throughput: one range sample per cycle within a scan.
// End of scan: after the end-marked sample the drive command reaches out_tvalid
// via load, 2*ceil(log2(MAX_SAMPLES+1)) + 16 divider steps (38 at the default
// size), scale and finish (held while the output stalls); no sample is taken then.
// Reset (rst_n low, synchronous): registers to their defaults, scan state cleared.
// ----------------------------------------------------------------------------
// scan_centroid_steering
// Steering command from the centroid of the in-window samples of a lidar scan.
// ----------------------------------------------------------------------------
module scan_centroid_steering #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // sample requests
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] range_sample
  input  logic        in_tlast,   // scan_end
  // drive command requests
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [12:0] linear_speed, [39:13] turn_rate
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int ANG_W  = 2 * CNT_W + scs_pkg::SAMPLE_W;

  logic [scs_pkg::SAMPLE_W-1:0] range_floor_r;
  logic [scs_pkg::SAMPLE_W-1:0] range_ceiling_r;
  logic [scs_pkg::SAMPLE_W-1:0] angle_step_r;

  scs_pkg::cmd_t                  cmd;
  logic                           out_free;
  logic [scs_pkg::SPEED_W-1:0]    res_speed;
  logic signed [scs_pkg::TURN_W-1:0] res_turn;

  logic                           out_valid_r;
  logic [scs_pkg::SPEED_W-1:0]    out_speed_r;
  logic [scs_pkg::TURN_W-1:0]     out_turn_r;

  // Configuration: always ready; writes to an unused index are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_floor_r   <= scs_pkg::RANGE_FLOOR_RST;
      range_ceiling_r <= scs_pkg::RANGE_CEILING_RST;
      angle_step_r    <= scs_pkg::ANGLE_STEP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        scs_pkg::REG_RANGE_FLOOR:   range_floor_r   <= cfg_data;
        scs_pkg::REG_RANGE_CEILING: range_ceiling_r <= cfg_data;
        scs_pkg::REG_ANGLE_STEP:    angle_step_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer: takes samples, then walks the divider through its steps
  scs_ctrl #(
    .DIV_STEPS (ANG_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .out_free  (out_free),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  // Datapath: sums, shared divider, scaling and the slow-speed fallback
  scs_dp #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .range_sample  (in_tdata[scs_pkg::SAMPLE_W-1:0]),
    .range_floor   (range_floor_r),
    .range_ceiling (range_ceiling_r),
    .angle_step    (angle_step_r),
    .res_speed     (res_speed),
    .res_turn      (res_turn)
  );

  // Output register: the next scan is accumulated while a command waits here
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Hold the payload while the request stalls
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_speed_r <= res_speed;
      out_turn_r  <= res_turn;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_turn_r, out_speed_r};

endmodule

>>> hdl/scs_ctrl.sv
// ----------------------------------------------------------------------------
// scs_ctrl
// Sequencer: accumulate a scan, then run the division and scaling steps.
// ----------------------------------------------------------------------------
module scs_ctrl #(
  parameter int DIV_STEPS = 38
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          in_tlast,
  input  logic          out_free,
  output logic          in_tready,
  output scs_pkg::cmd_t cmd
);

  localparam int CW = $clog2(DIV_STEPS);

  scs_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   step_r, step_nxt;
  logic            last_step;

  assign last_step = (step_r == CW'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scs_pkg::ST_ACCUM;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      scs_pkg::ST_ACCUM: begin
        in_tready = 1'b1;
        cmd.accum = in_tvalid;
        if (in_tvalid && in_tlast) begin
          state_nxt = scs_pkg::ST_LOAD;
        end
      end
      scs_pkg::ST_LOAD: begin
        cmd.div_load = 1'b1;
        step_nxt     = '0;
        state_nxt    = scs_pkg::ST_DIVIDE;
      end
      scs_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + CW'(1);
        if (last_step) begin
          state_nxt = scs_pkg::ST_SCALE;
        end
      end
      scs_pkg::ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = scs_pkg::ST_FINISH;
      end
      scs_pkg::ST_FINISH: begin
        // hold until the output slot is free
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = scs_pkg::ST_ACCUM;
        end
      end
      default: begin
        state_nxt = scs_pkg::ST_ACCUM;
      end
    endcase
  end

endmodule

>>> hdl/scs_dp.sv
// ----------------------------------------------------------------------------
// scs_dp
// Accumulators, shared restoring divider, divide-by-ten and result select.
// ----------------------------------------------------------------------------
module scs_dp #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  scs_pkg::cmd_t                   cmd,
  input  logic [scs_pkg::SAMPLE_W-1:0]    range_sample,
  input  logic [scs_pkg::SAMPLE_W-1:0]    range_floor,
  input  logic [scs_pkg::SAMPLE_W-1:0]    range_ceiling,
  input  logic [scs_pkg::SAMPLE_W-1:0]    angle_step,
  output logic [scs_pkg::SPEED_W-1:0]     res_speed,
  output logic signed [scs_pkg::TURN_W-1:0] res_turn
);

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int IDX_W  = CNT_W;
  localparam int PROD_W = IDX_W + scs_pkg::SAMPLE_W;
  localparam int ANG_W  = PROD_W + CNT_W;
  localparam int RNG_W  = scs_pkg::SAMPLE_W + CNT_W;
  localparam int EXT_W  = ANG_W + scs_pkg::TURN_W;

  logic [CNT_W-1:0]  cnt_r;
  logic [IDX_W-1:0]  idx_r;
  logic [ANG_W-1:0]  ang_tot_r;
  logic [RNG_W-1:0]  rng_tot_r;

  logic              in_window;
  logic              sample_ok;
  logic [PROD_W-1:0] angle_inc;

  // Divider: both totals share the divisor and the step count
  logic [ANG_W-1:0]  ang_div_r, ang_div_nxt;
  logic [ANG_W-1:0]  rng_div_r, rng_div_nxt;
  logic [CNT_W-1:0]  ang_rem_r, ang_rem_nxt;
  logic [CNT_W-1:0]  rng_rem_r, rng_rem_nxt;
  logic [CNT_W-1:0]  divisor_r;
  logic [CNT_W:0]    ang_sh, rng_sh, ang_diff, rng_diff;
  logic              ang_ge, rng_ge;

  logic [scs_pkg::RECIP_W-1:0] prod_r;
  logic [scs_pkg::SPEED_W-1:0] speed_raw;
  logic [EXT_W-1:0]            ang_ext;
  logic                        slow;

  assign in_window = (idx_r < IDX_W'(MAX_SAMPLES));
  assign sample_ok = (range_sample > range_floor) && (range_sample < range_ceiling);
  assign angle_inc = PROD_W'(idx_r) * PROD_W'(angle_step);

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.finish) begin
      cnt_r     <= '0;
      idx_r     <= '0;
      ang_tot_r <= '0;
      rng_tot_r <= '0;
    end else if (cmd.accum && in_window) begin
      idx_r <= idx_r + IDX_W'(1);
      if (sample_ok) begin
        cnt_r     <= cnt_r + CNT_W'(1);
        ang_tot_r <= ang_tot_r + ANG_W'(angle_inc);
        rng_tot_r <= rng_tot_r + RNG_W'(range_sample);
      end
    end
  end

  always_comb begin
    ang_sh   = {ang_rem_r, ang_div_r[ANG_W-1]};
    rng_sh   = {rng_rem_r, rng_div_r[ANG_W-1]};
    ang_ge   = (ang_sh >= {1'b0, divisor_r});
    rng_ge   = (rng_sh >= {1'b0, divisor_r});
    ang_diff = ang_sh - {1'b0, divisor_r};
    rng_diff = rng_sh - {1'b0, divisor_r};
    ang_rem_nxt = ang_ge ? ang_diff[CNT_W-1:0] : ang_sh[CNT_W-1:0];
    rng_rem_nxt = rng_ge ? rng_diff[CNT_W-1:0] : rng_sh[CNT_W-1:0];
    ang_div_nxt = {ang_div_r[ANG_W-2:0], ang_ge};
    rng_div_nxt = {rng_div_r[ANG_W-2:0], rng_ge};
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      ang_div_r <= ang_tot_r;
      rng_div_r <= ANG_W'(rng_tot_r);
      ang_rem_r <= '0;
      rng_rem_r <= '0;
      divisor_r <= cnt_r;
    end else if (cmd.div_step) begin
      ang_div_r <= ang_div_nxt;
      rng_div_r <= rng_div_nxt;
      ang_rem_r <= ang_rem_nxt;
      rng_rem_r <= rng_rem_nxt;
    end
  end

  // mean range fits 16 bits once the divisor is non-zero
  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      prod_r <= scs_pkg::RECIP_W'(rng_div_r[scs_pkg::SAMPLE_W-1:0]) * scs_pkg::RECIP_TEN;
    end
  end

  always_comb begin
    speed_raw = prod_r[scs_pkg::RECIP_SHIFT +: scs_pkg::SPEED_W];
    ang_ext   = {{scs_pkg::TURN_W{1'b0}}, ang_div_r};
    slow      = (divisor_r == '0) || (speed_raw < scs_pkg::SLOW_LIMIT);
    if (slow) begin
      res_speed = scs_pkg::DEFAULT_SPEED;
      res_turn  = '0;
    end else begin
      res_speed = speed_raw;
      res_turn  = ang_ext[scs_pkg::TURN_W-1:0] - scs_pkg::PI_FIXED;
    end
  end

endmodule
